// File: hdl/blrc_pkg.sv
package blrc_pkg;

    // Fixed field widths of the ports.
    localparam int DATA_W  = 64;
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 5;
    localparam int OP_W    = 2;

    // Reset value of the capacity register.
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

    // Operation codes carried by each input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_NEWER  = 2'd1,
        OP_OLDER  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Sequencer states of the top level.
    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } t_state;

endpackage

// File: hdl/bounded_log_ring_with_cursor.sv
// Bounded log ring with a browsing cursor.
//
// Input channel (i_valid / o_ready) carries one operation per transaction:
// append i_entry_data, move the cursor newer, move it older, or clear all.
// Output channel (o_valid / i_ready) returns one transaction per input with
// the record under the cursor, the cursor valid flag and the record count.
// The capacity register is written through i_cfg_we / i_cfg_wdata.
//
// Flow: at acceptance the cursor record is read into the registered read port
// of the record memory, and the result is then loaded into the output register.
// The block holds one operation at a time and accepts the next after that load.
// While a result waits in the output register the next operation is still
// accepted; its own result then waits until the output register drains.
//
// Reset (synchronous, active low) empties the ring, unsets the cursor and
// sets the capacity to sixteen. Stored records are not cleared.
module bounded_log_ring_with_cursor #(
    parameter int DEPTH       = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [blrc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [blrc_pkg::OP_W-1:0]      i_operation,
    input  logic [blrc_pkg::DATA_W-1:0]    i_entry_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_cursor_valid,
    output logic [blrc_pkg::DATA_W-1:0]    o_cursor_data,
    output logic [blrc_pkg::COUNT_W-1:0]   o_entry_count
);
    import blrc_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]       r_max_entries;
    logic                   r_out_valid;
    logic                   r_out_cursor_valid;
    logic [DATA_W-1:0]      r_out_cursor_data;
    logic [COUNT_W-1:0]     r_out_count;

    logic                   accept;
    logic                   load_out;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_slot;
    logic [SLOT_W-1:0]      rd_slot;
    logic                   cursor_set;
    logic [CNT_W-1:0]       count;
    logic [EXT_W-1:0]       count_ext;
    logic [RECORD_BITS-1:0] rd_data;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    // Pointer and cursor state.
    blrc_cursor #(
        .DEPTH(DEPTH)
    ) u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_op         (t_op'(i_operation)),
        .i_max_entries(r_max_entries),
        .o_wr_en      (wr_en),
        .o_wr_slot    (wr_slot),
        .o_rd_slot    (rd_slot),
        .o_cursor_set (cursor_set),
        .o_count      (count)
    );

    // Record storage; the cursor slot is read in the same cycle as the update.
    blrc_mem #(
        .DEPTH(DEPTH),
        .WIDTH(RECORD_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_slot),
        .i_wdata(i_entry_data[RECORD_BITS-1:0]),
        .i_re   (accept),
        .i_raddr(rd_slot),
        .o_rdata(rd_data)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        o_ready  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_RESP: begin
                load_out = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register; it holds its transaction until the receiver takes it.
    assign count_ext = EXT_W'(count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_cursor_valid <= cursor_set;
            r_out_cursor_data  <= cursor_set ? DATA_W'(rd_data) : '0;
            r_out_count        <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cursor_valid = r_out_cursor_valid;
    assign o_cursor_data  = r_out_cursor_data;
    assign o_entry_count  = r_out_count;

endmodule

// File: hdl/blrc_mem.sv
module blrc_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/blrc_cursor.sv
module blrc_cursor #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  blrc_pkg::t_op                i_op,
    input  logic [blrc_pkg::CFG_W-1:0]   i_max_entries,
    output logic                         o_wr_en,
    output logic [$clog2(DEPTH)-1:0]     o_wr_slot,
    output logic [$clog2(DEPTH)-1:0]     o_rd_slot,
    output logic                         o_cursor_set,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import blrc_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int EXT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_cursor_slot, n_cursor_slot;
    logic              r_cursor_set, n_cursor_set;

    logic [EXT_W-1:0]  cap;
    logic              full;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_m1;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] newest_slot;
    logic [SLOT_W-1:0] oldest_next;
    logic [SLOT_W-1:0] cursor_next;
    logic [SLOT_W-1:0] cursor_prev;

    // Effective capacity: zero acts as one, anything above the ring size as the ring size.
    always_comb begin
        if (i_max_entries == '0) begin
            cap = EXT_W'(1);
        end else if (EXT_W'(i_max_entries) > EXT_W'(DEPTH)) begin
            cap = EXT_W'(DEPTH);
        end else begin
            cap = EXT_W'(i_max_entries);
        end
    end

    assign full = (EXT_W'(r_count) >= cap);

    // Slot arithmetic on the ring; the sum stays below twice the ring size.
    assign sum    = SUM_W'(r_oldest) + SUM_W'(r_count);
    assign sum_m1 = sum - SUM_W'(1);
    assign tail_slot   = (sum >= SUM_W'(DEPTH)) ? SLOT_W'(sum - SUM_W'(DEPTH)) : SLOT_W'(sum);
    assign newest_slot = (sum_m1 >= SUM_W'(DEPTH)) ? SLOT_W'(sum_m1 - SUM_W'(DEPTH))
                                                   : SLOT_W'(sum_m1);
    assign oldest_next = (r_oldest == LAST_SLOT) ? '0 : r_oldest + SLOT_W'(1);
    assign cursor_next = (r_cursor_slot == LAST_SLOT) ? '0 : r_cursor_slot + SLOT_W'(1);
    assign cursor_prev = (r_cursor_slot == '0) ? LAST_SLOT : r_cursor_slot - SLOT_W'(1);

    // Next pointer state for one operation.
    always_comb begin
        n_oldest      = r_oldest;
        n_count       = r_count;
        n_cursor_slot = r_cursor_slot;
        n_cursor_set  = r_cursor_set;
        o_wr_en       = 1'b0;
        if (i_step) begin
            case (i_op)
                OP_APPEND: begin
                    o_wr_en = 1'b1;
                    if (full) begin
                        // The oldest record is dropped; a cursor on it loses its place.
                        if (r_cursor_set && (r_cursor_slot == r_oldest)) begin
                            n_cursor_set = 1'b0;
                        end
                        n_oldest = oldest_next;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_NEWER: begin
                    if (r_count == '0) begin
                        n_cursor_set = 1'b0;
                    end else if (r_cursor_set && (r_cursor_slot != newest_slot)) begin
                        n_cursor_slot = cursor_next;
                    end else begin
                        n_cursor_slot = r_oldest;
                        n_cursor_set  = 1'b1;
                    end
                end
                OP_OLDER: begin
                    if (r_count == '0) begin
                        n_cursor_set = 1'b0;
                    end else if (r_cursor_set && (r_cursor_slot != r_oldest)) begin
                        n_cursor_slot = cursor_prev;
                    end else begin
                        n_cursor_slot = newest_slot;
                        n_cursor_set  = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_count      = '0;
                    n_oldest     = '0;
                    n_cursor_set = 1'b0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest      <= '0;
            r_count       <= '0;
            r_cursor_slot <= '0;
            r_cursor_set  <= 1'b0;
        end else begin
            r_oldest      <= n_oldest;
            r_count       <= n_count;
            r_cursor_slot <= n_cursor_slot;
            r_cursor_set  <= n_cursor_set;
        end
    end

    assign o_wr_slot    = tail_slot;
    assign o_rd_slot    = n_cursor_slot;
    assign o_cursor_set = r_cursor_set;
    assign o_count      = r_count;

endmodule

// File: hdl/blrc_checker.sv
module blrc_assertions #(
    parameter int DEPTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_cursor_valid,
    input logic [blrc_pkg::DATA_W-1:0]    o_cursor_data,
    input logic [blrc_pkg::COUNT_W-1:0]   o_entry_count
);
    import blrc_pkg::*;

    // A stalled result stays presented with its payload unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_data)
                                && $stable(o_entry_count) && $stable(o_cursor_valid))
        else $error("stalled result changed");

    // An unset cursor reports an all-zero record.
    a_unset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_cursor_valid |-> o_cursor_data == '0)
        else $error("unset cursor carries data");

    // A set cursor needs at least one stored record.
    a_set_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cursor_valid |-> o_entry_count != '0)
        else $error("cursor set on an empty store");

    // Reset removes any pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind bounded_log_ring_with_cursor blrc_assertions #(
    .DEPTH(DEPTH)
) u_blrc_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_cursor_valid(o_cursor_valid),
    .o_cursor_data (o_cursor_data),
    .o_entry_count (o_entry_count)
);

// File: dv/blrc_checker.sv
module blrc_checker #(
    parameter int DEPTH       = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [blrc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  blrc_pkg::t_op                  i_operation,
    input  logic [blrc_pkg::DATA_W-1:0]    i_entry_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_cursor_valid,
    input  logic [blrc_pkg::DATA_W-1:0]    i_cursor_data,
    input  logic [blrc_pkg::COUNT_W-1:0]   i_entry_count,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_discards,
    output int                             o_cursor_drops
);
    timeunit 1ns;
    timeprecision 1ps;
    import blrc_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;
    localparam logic [DATA_W-1:0] RECORD_MASK =
        (RECORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << RECORD_BITS) - 1'b1);

    // What the output channel should show after one operation.
    typedef struct packed {
        logic               cursor_valid;
        logic [DATA_W-1:0]  cursor_data;
        logic [COUNT_W-1:0] entry_count;
    } t_log_view;

    // Shadow copy of the ring, its pointers and the capacity register.
    logic [DATA_W-1:0]  record_store [DEPTH];
    logic [SLOT_W-1:0]  oldest_slot;
    logic [COUNT_W-1:0] record_count;
    logic [SLOT_W-1:0]  cursor_slot;
    logic               cursor_set;
    logic [CFG_W-1:0]   max_entries;

    t_log_view expected_views [$];

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            record_store[i] = '0;
        end
        oldest_slot    = '0;
        record_count   = '0;
        cursor_slot    = '0;
        cursor_set     = 1'b0;
        max_entries    = MAX_ENTRIES_RESET;
        o_mismatches   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_discards     = 0;
        o_cursor_drops = 0;
    end

    function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] slot);
        return (int'(slot) == DEPTH - 1) ? '0 : slot + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_before(logic [SLOT_W-1:0] slot);
        return (slot == '0) ? SLOT_W'(DEPTH - 1) : slot - 1'b1;
    endfunction

    // Slot of the newest record; only meaningful while the ring holds records.
    function automatic logic [SLOT_W-1:0] newest_slot();
        return SLOT_W'((int'(oldest_slot) + int'(record_count) - 1) % DEPTH);
    endfunction

    // Apply one operation to the shadow ring and return the view it leaves.
    function automatic t_log_view apply_operation(t_op op, logic [DATA_W-1:0] data);
        int        limit;
        int        write_slot;
        t_log_view view;
        // Out-of-range capacities are clamped to the legal span.
        limit = int'(max_entries);
        if (limit < 1) limit = 1;
        if (limit > DEPTH) limit = DEPTH;
        case (op)
            OP_APPEND: begin
                write_slot = (int'(oldest_slot) + int'(record_count)) % DEPTH;
                // A full ring drops exactly one oldest record, even when the
                // capacity was lowered below the current count.
                if (int'(record_count) >= limit && record_count != '0) begin
                    if (cursor_set && cursor_slot == oldest_slot) begin
                        cursor_set = 1'b0;
                        o_cursor_drops++;
                    end
                    oldest_slot  = slot_after(oldest_slot);
                    record_count = record_count - 1'b1;
                    o_discards++;
                end
                record_store[write_slot] = data & RECORD_MASK;
                record_count = record_count + 1'b1;
            end
            OP_NEWER: begin
                if (record_count == '0) begin
                    cursor_set = 1'b0;
                end else if (cursor_set && cursor_slot != newest_slot()) begin
                    cursor_slot = slot_after(cursor_slot);
                end else begin
                    // Unset or at the newest record: wrap to the oldest.
                    cursor_slot = oldest_slot;
                    cursor_set  = 1'b1;
                end
            end
            OP_OLDER: begin
                if (record_count == '0) begin
                    cursor_set = 1'b0;
                end else if (cursor_set && cursor_slot != oldest_slot) begin
                    cursor_slot = slot_before(cursor_slot);
                end else begin
                    // Unset or at the oldest record: wrap to the newest.
                    cursor_slot = newest_slot();
                    cursor_set  = 1'b1;
                end
            end
            default: begin
                record_count = '0;
                oldest_slot  = '0;
                cursor_set   = 1'b0;
            end
        endcase
        view.cursor_valid = cursor_set;
        view.cursor_data  = cursor_set ? record_store[cursor_slot] : '0;
        view.entry_count  = record_count;
        return view;
    endfunction

    // Sample both channels at the rising edge. Results are compared before the
    // new prediction is queued, since a result never belongs to an operation
    // accepted at the same edge.
    always @(posedge i_clk) begin
        t_log_view wanted;
        t_log_view seen;
        if (!i_rst_n) begin
            oldest_slot  = '0;
            record_count = '0;
            cursor_slot  = '0;
            cursor_set   = 1'b0;
            max_entries  = MAX_ENTRIES_RESET;
            expected_views.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.cursor_valid = i_cursor_valid;
                seen.cursor_data  = i_cursor_data;
                seen.entry_count  = i_entry_count;
                if (expected_views.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT) begin
                        $display("blrc_checker: unexpected result transaction: valid=%0b",
                                 seen.cursor_valid, " data=%h count=%0d",
                                 seen.cursor_data, seen.entry_count);
                    end
                end else begin
                    wanted = expected_views.pop_front();
                    o_checked++;
                    if (seen.cursor_valid !== wanted.cursor_valid ||
                        seen.cursor_data !== wanted.cursor_data ||
                        seen.entry_count !== wanted.entry_count) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("blrc_checker: result %0d expected valid=%0b data=%h",
                                     o_checked, wanted.cursor_valid, wanted.cursor_data,
                                     " count=%0d", wanted.entry_count);
                            $display("blrc_checker: result %0d actual   valid=%0b data=%h",
                                     o_checked, seen.cursor_valid, seen.cursor_data,
                                     " count=%0d", seen.entry_count);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                max_entries = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                expected_views.push_back(apply_operation(i_operation, i_entry_data));
            end
        end
        o_pending = expected_views.size();
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import blrc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 147;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    t_op                  i_operation = OP_APPEND;
    logic [DATA_W-1:0]    i_entry_data = '0;
    logic                 i_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_cursor_valid;
    logic [DATA_W-1:0]    o_cursor_data;
    logic [COUNT_W-1:0]   o_entry_count;

    int mismatches;
    int pending;
    int checked;
    int discards;
    int cursor_drops;

    int src_idle_pct = 31;
    int sink_idle_pct = 88;
    int idle_cycles = 0;
    int op_totals [4] = '{0, 0, 0, 0};
    int capacity_writes = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    bounded_log_ring_with_cursor uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_entry_data   (i_entry_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cursor_valid (o_cursor_valid),
        .o_cursor_data  (o_cursor_data),
        .o_entry_count  (o_entry_count)
    );

    blrc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_operation    (i_operation),
        .i_entry_data   (i_entry_data),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_cursor_valid (o_cursor_valid),
        .i_cursor_data  (o_cursor_data),
        .i_entry_count  (o_entry_count),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_discards     (discards),
        .o_cursor_drops (cursor_drops)
    );

    // Result receiver: stall at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: watchdog expired after %0d quiet cycles", idle_cycles);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Offer one operation, with a random hold-off first; returns at the
    // falling edge after the transaction was accepted.
    task automatic send_op(t_op op, logic [DATA_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_entry_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        op_totals[int'(op)]++;
        @(negedge i_clk);
    endtask

    // Let every outstanding result drain, then let the block settle with the input idle.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        capacity_writes++;
    endtask

    // Mostly appends and cursor moves with an occasional clear, so the ring
    // fills up and wraps between clears.
    task automatic send_random_op();
        int                roll;
        int                pick;
        t_op               op;
        logic [DATA_W-1:0] data;
        roll = $urandom_range(99);
        if (roll < 48) op = OP_APPEND;
        else if (roll < 72) op = OP_NEWER;
        else if (roll < 97) op = OP_OLDER;
        else op = OP_CLEAR;
        pick = $urandom_range(15);
        if (pick == 0) data = '0;
        else if (pick == 1) data = '1;
        else data = {$urandom, $urandom};
        send_op(op, data);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_caps [PHASES];
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, CFG_W'($urandom_range(2, 15))};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: moves on an empty ring, wrap in both directions, clear.
        send_op(OP_OLDER, '1);
        send_op(OP_NEWER, '1);
        send_op(OP_APPEND, '0);
        send_op(OP_APPEND, '1);
        send_op(OP_APPEND, 64'hA5A5_5A5A_0F0F_F0F0);
        send_op(OP_NEWER, '0);
        send_op(OP_NEWER, '0);
        send_op(OP_NEWER, '0);
        send_op(OP_NEWER, '0);
        send_op(OP_OLDER, '0);
        send_op(OP_OLDER, '0);
        send_op(OP_CLEAR, '1);
        send_op(OP_NEWER, '0);
        send_op(OP_APPEND, 64'h8000_0000_0000_0001);

        // Directed: the cursor sits on the oldest record when it is discarded.
        settle();
        write_capacity(5'd2);
        send_op(OP_NEWER, '0);
        send_op(OP_APPEND, 64'h0123_4567_89AB_CDEF);
        send_op(OP_APPEND, 64'hFEDC_BA98_7654_3210);
        send_op(OP_OLDER, '0);

        // Directed: capacity below the count, with zero acting as one.
        settle();
        write_capacity(5'd0);
        send_op(OP_APPEND, 64'h5555_AAAA_5555_AAAA);
        send_op(OP_NEWER, '0);
        send_op(OP_OLDER, '0);
        settle();
        write_capacity(5'd31);
        send_op(OP_CLEAR, '0);

        // Random phases, each with its own capacity; the stall pattern is set per group of phases.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase < 2) begin
                src_idle_pct  = 31;
                sink_idle_pct = 88;
            end else if (phase < 4) begin
                src_idle_pct  = 88;
                sink_idle_pct = 31;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_capacity(phase_caps[phase]);
            repeat (PHASE_ITEMS) send_random_op();
        end
        settle();

        $display("tb_top: %0d operations sent: %0d append, %0d newer, %0d older, %0d clear",
                 op_totals[0] + op_totals[1] + op_totals[2] + op_totals[3],
                 op_totals[0], op_totals[1], op_totals[2], op_totals[3]);
        $display("tb_top: %0d results checked, %0d capacity writes, %0d records discarded",
                 checked, capacity_writes, discards, ", %0d cursor drops, %0d mismatches",
                 cursor_drops, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
